[rtl/box_sum_3x3_zero_border_macros.svh]
// assertion macros for the 3x3 box sum block
// expects clk and rst (active high) in the scope of use
`ifndef BOX_SUM_3X3_ZERO_BORDER_MACROS_SVH
`define BOX_SUM_3X3_ZERO_BORDER_MACROS_SVH

// same-cycle implication
`define BSS_CHECK(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define BSS_CHECK_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/bss_pkg.sv]
// shared types, widths and helpers for the 3x3 box sum block
// no dependencies
package bss_pkg;

  localparam int PIX_W      = 4;
  localparam int SUM_W      = 7;
  localparam int ROW_W      = 12;
  localparam int COL_OUT_W  = 5;
  localparam int COL_IDX_W  = 6;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 1;
  localparam int VSUM_W     = 6;
  localparam int HSUM_W     = 8;
  localparam int NSLOT      = 4;
  localparam int QDEPTH     = 4;

  localparam logic [CFG_IDX_W-1:0] REG_FRAME_COLS = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_FRAME_ROWS = 1'd1;

  // result slots of one pixel, in emission order
  typedef enum logic [1:0] {
    SLOT_PREV_UP,
    SLOT_PREV_LOW,
    SLOT_LAST_UP,
    SLOT_LAST_LOW
  } slot_t;

  typedef struct packed {
    logic [COL_IDX_W-1:0] col_last;
    logic [ROW_W-1:0]     row_last;
  } frame_cfg_t;

  typedef struct packed {
    logic [NSLOT-1:0][SUM_W-1:0] sums;
    logic [NSLOT-1:0]            slot_valid;
    logic [ROW_W-1:0]            row;
    logic [COL_IDX_W-1:0]        col;
  } run_entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

  function automatic logic [SUM_W-1:0] sat_sum(input logic [HSUM_W-1:0] s);
    logic [HSUM_W-1:0] top;
    top = HSUM_W'((2 ** SUM_W) - 1);
    return (s > top) ? top[SUM_W-1:0] : s[SUM_W-1:0];
  endfunction

endpackage

[rtl/bss_ifs.sv]
// valid/ready channel interfaces: pixel input and sum result output
// depends on bss_pkg
interface bss_pixel_if;
  import bss_pkg::*;
  logic             valid;
  logic             ready;
  logic [PIX_W-1:0] pixel;
  modport source (output valid, output pixel, input ready);
  modport sink (input valid, input pixel, output ready);
endinterface

interface bss_result_if;
  import bss_pkg::*;
  logic                 valid;
  logic                 ready;
  logic [SUM_W-1:0]     window_sum;
  logic [ROW_W-1:0]     out_row;
  logic [COL_OUT_W-1:0] out_col;
  logic                 last_of_run;
  logic                 frame_done;
  modport source (output valid, output window_sum, output out_row, output out_col,
                  output last_of_run, output frame_done, input ready);
  modport sink (input valid, input window_sum, input out_row, input out_col,
                input last_of_run, input frame_done, output ready);
endinterface

[rtl/bss_ram.sv]
// generic simple dual-port ram, one write port, one registered read port
// no dependencies
module bss_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 32,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/bss_queue.sv]
// short fifo of per-pixel result runs between front and back
// depends on bss_pkg
module bss_queue (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   push,
  input  bss_pkg::run_entry_t    push_entry,
  input  logic                   pop,
  output bss_pkg::run_entry_t    head,
  output bss_pkg::queue_status_t status
);
  import bss_pkg::*;

  localparam int PW = $clog2(QDEPTH);
  localparam int CNT_W = $clog2(QDEPTH + 1);

  run_entry_t        slots [QDEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [CNT_W-1:0]  count;

  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

  assign head         = slots[rd_ptr];
  assign status.full  = (count == CNT_W'(QDEPTH));
  assign status.empty = (count == '0);

endmodule

[rtl/bss_front.sv]
// front end: accepts pixels, keeps the three line stores and the column
// window, builds the run of sums that each pixel releases; uses bss_ram, bss_pkg, bss_ifs
module bss_front #(
  parameter int MAX_COLS = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  bss_pkg::frame_cfg_t   cfg,
  input  logic                  restart,
  bss_pixel_if.sink             pixels,
  input  bss_pkg::queue_status_t q_stat,
  output logic                  q_push,
  output bss_pkg::run_entry_t   q_entry
);
  import bss_pkg::*;

  localparam int CW = $clog2(MAX_COLS);

  logic [CW-1:0]    in_col;
  logic [ROW_W-1:0] in_row;
  logic [2:0]       cur_sel;
  logic             accept;
  logic             last_col;
  logic             last_row;
  logic [PIX_W-1:0] rd [3];

  logic             s1_valid;
  logic [PIX_W-1:0] s1_pix;
  logic [ROW_W-1:0] s1_row;
  logic [CW-1:0]    s1_col;
  logic             s1_last_col;
  logic             s1_last_row;
  logic [2:0]       s1_sel;

  logic [VSUM_W-1:0] vu1, vu2, vl1, vl2;
  logic [VSUM_W-1:0] vu, vl, p1u, p2u, p1l, p2l;
  logic [2:0]        mid_sel, above_sel;
  logic [PIX_W-1:0]  mid_px, above_px;
  logic [NSLOT-1:0]  slot_valid;
  logic              advance;

  assign accept   = pixels.valid && pixels.ready;
  assign last_col = (in_col == CW'(cfg.col_last));
  assign last_row = (in_row == cfg.row_last);

  always_ff @(posedge clk) begin
    if (rst) begin
      in_col  <= '0;
      in_row  <= '0;
      cur_sel <= 3'b001;
    end else if (restart) begin
      in_col <= '0;
      in_row <= '0;
    end else if (accept) begin
      if (!last_col) begin
        in_col <= in_col + CW'(1);
      end else begin
        in_col  <= '0;
        in_row  <= last_row ? '0 : in_row + ROW_W'(1);
        // rotate line roles: current becomes middle, middle becomes above
        cur_sel <= {cur_sel[1:0], cur_sel[2]};
      end
    end
  end

  for (genvar i = 0; i < 3; i++) begin : g_line
    bss_ram #(.WIDTH(PIX_W), .DEPTH(MAX_COLS)) u_line (
      .clk   (clk),
      .we    (accept && cur_sel[i]),
      .waddr (in_col),
      .wdata (pixels.pixel),
      .re    (accept),
      .raddr (in_col),
      .rdata (rd[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix      <= pixels.pixel;
      s1_row      <= in_row;
      s1_col      <= in_col;
      s1_last_col <= last_col;
      s1_last_row <= last_row;
      s1_sel      <= cur_sel;
    end
  end

  assign mid_sel   = {s1_sel[0], s1_sel[2:1]};
  assign above_sel = {s1_sel[1:0], s1_sel[2]};

  always_comb begin
    mid_px   = '0;
    above_px = '0;
    for (int i = 0; i < 3; i++) begin
      if (mid_sel[i]) begin
        mid_px = rd[i];
      end
      if (above_sel[i]) begin
        above_px = rd[i];
      end
    end
  end

  // column sums: upper centred on row r-1, lower centred on the last row r
  always_comb begin
    vu = ((s1_row >= ROW_W'(2)) ? VSUM_W'(above_px) : '0) + VSUM_W'(mid_px)
         + VSUM_W'(s1_pix);
    vl = ((s1_row != '0) ? VSUM_W'(mid_px) : '0) + VSUM_W'(s1_pix);
    p1u = (s1_col != '0) ? vu1 : '0;
    p1l = (s1_col != '0) ? vl1 : '0;
    p2u = (s1_col >= CW'(2)) ? vu2 : '0;
    p2l = (s1_col >= CW'(2)) ? vl2 : '0;
  end

  always_comb begin
    slot_valid                = '0;
    slot_valid[SLOT_PREV_UP]  = (s1_col != '0) && (s1_row != '0);
    slot_valid[SLOT_PREV_LOW] = (s1_col != '0) && s1_last_row;
    slot_valid[SLOT_LAST_UP]  = s1_last_col && (s1_row != '0);
    slot_valid[SLOT_LAST_LOW] = s1_last_col && s1_last_row;
  end

  assign advance      = s1_valid && ((slot_valid == '0) || !q_stat.full);
  assign pixels.ready = !s1_valid || advance;
  assign q_push       = advance && (slot_valid != '0);

  always_comb begin
    q_entry                      = '0;
    q_entry.slot_valid           = slot_valid;
    q_entry.row                  = s1_row;
    q_entry.col                  = COL_IDX_W'(s1_col);
    q_entry.sums[SLOT_PREV_UP]   = sat_sum(HSUM_W'(p2u) + HSUM_W'(p1u) + HSUM_W'(vu));
    q_entry.sums[SLOT_PREV_LOW]  = sat_sum(HSUM_W'(p2l) + HSUM_W'(p1l) + HSUM_W'(vl));
    q_entry.sums[SLOT_LAST_UP]   = sat_sum(HSUM_W'(p1u) + HSUM_W'(vu));
    q_entry.sums[SLOT_LAST_LOW]  = sat_sum(HSUM_W'(p1l) + HSUM_W'(vl));
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      vu1 <= vu;
      vu2 <= vu1;
      vl1 <= vl;
      vl2 <= vl1;
    end
  end

endmodule

[rtl/bss_back.sv]
// back end: walks each queued run and sends its sums one per cycle while
// the port is ready, via a registered output stage; depends on bss_pkg, bss_ifs
module bss_back (
  input  logic                   clk,
  input  logic                   rst,
  input  bss_pkg::run_entry_t    head,
  input  bss_pkg::queue_status_t q_stat,
  output logic                   q_pop,
  bss_result_if.source           sums
);
  import bss_pkg::*;

  logic [NSLOT-1:0]     taken;
  logic [NSLOT-1:0]     remaining;
  logic [NSLOT-1:0]     rest;
  slot_t                sel;
  logic                 load;
  logic                 is_last;

  logic                 out_valid;
  logic [SUM_W-1:0]     out_sum;
  logic [ROW_W-1:0]     out_row;
  logic [COL_OUT_W-1:0] out_col;
  logic                 out_last;
  logic                 out_done;

  assign remaining = head.slot_valid & ~taken;

  always_comb begin
    priority if (remaining[SLOT_PREV_UP]) begin
      sel = SLOT_PREV_UP;
    end else if (remaining[SLOT_PREV_LOW]) begin
      sel = SLOT_PREV_LOW;
    end else if (remaining[SLOT_LAST_UP]) begin
      sel = SLOT_LAST_UP;
    end else begin
      sel = SLOT_LAST_LOW;
    end
  end

  always_comb begin
    rest      = remaining;
    rest[sel] = 1'b0;
  end

  assign is_last = (rest == '0);
  assign load    = !q_stat.empty && (!out_valid || sums.ready);
  assign q_pop   = load && is_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      taken     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (load) begin
        taken     <= is_last ? '0 : (taken | (NSLOT'(1) << sel));
        out_valid <= 1'b1;
      end else if (sums.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_sum  <= head.sums[sel];
      out_row  <= (sel == SLOT_PREV_UP || sel == SLOT_LAST_UP) ?
                  head.row - ROW_W'(1) : head.row;
      out_col  <= (sel == SLOT_PREV_UP || sel == SLOT_PREV_LOW) ?
                  COL_OUT_W'(head.col - COL_IDX_W'(1)) : COL_OUT_W'(head.col);
      out_last <= is_last;
      out_done <= (sel == SLOT_LAST_LOW);
    end
  end

  assign sums.valid       = out_valid;
  assign sums.window_sum  = out_sum;
  assign sums.out_row     = out_row;
  assign sums.out_col     = out_col;
  assign sums.last_of_run = out_last;
  assign sums.frame_done  = out_done;

endmodule

[rtl/box_sum_3x3_zero_border.sv]
// 3x3 box sum with a zero border over a row-major stream of digit pixels.
// A pixel is taken every cycle unless the run queue is full; its sums come
// out one per cycle on the result channel while it is ready, and trail the
// input by one row plus one pixel. A pixel in the last column releases two
// sums, a pixel in the last row two, the final pixel of a frame four, so the
// result port (one sum per cycle) sets the sustained rate; a four-entry run
// queue between the line-store front end and the output stage absorbs these
// bursts. Each pixel is written into the current line's ram and read from
// all three. Writing either frame register restarts the frame at row 0,
// column 0; no clearing pass follows reset.
module box_sum_3x3_zero_border #(
  parameter int MAX_COLS = 32
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_we,
  input  logic [bss_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [bss_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  bss_pixel_if.sink                          pixels,
  bss_result_if.source                       sums
);
  import bss_pkg::*;

  `include "box_sum_3x3_zero_border_macros.svh"

  localparam int RESET_COLS = (MAX_COLS < 10) ? MAX_COLS : 10;

  frame_cfg_t           cfg;
  logic                 restart;
  logic [5:0]           cols_val;
  logic [ROW_W-1:0]     rows_val;
  logic                 q_push;
  logic                 q_pop;
  run_entry_t           q_entry;
  run_entry_t           q_head;
  queue_status_t        q_stat;

  assign cols_val = cfg_wdata[5:0];
  assign rows_val = cfg_wdata[ROW_W-1:0];
  assign restart  = cfg_we;

  // store the last column and row index, with out-of-range values clamped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.col_last <= COL_IDX_W'(RESET_COLS - 1);
      cfg.row_last <= ROW_W'(9);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_FRAME_COLS: begin
          if (cols_val == '0) begin
            cfg.col_last <= '0;
          end else if (cols_val > MAX_COLS) begin
            cfg.col_last <= COL_IDX_W'(MAX_COLS - 1);
          end else begin
            cfg.col_last <= COL_IDX_W'(cols_val - 6'd1);
          end
        end
        REG_FRAME_ROWS: begin
          cfg.row_last <= (rows_val == '0) ? '0 : rows_val - ROW_W'(1);
        end
      endcase
    end
  end

  bss_front #(.MAX_COLS(MAX_COLS)) u_front (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .restart (restart),
    .pixels  (pixels),
    .q_stat  (q_stat),
    .q_push  (q_push),
    .q_entry (q_entry)
  );

  bss_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_entry (q_entry),
    .pop        (q_pop),
    .head       (q_head),
    .status     (q_stat)
  );

  bss_back u_back (
    .clk    (clk),
    .rst    (rst),
    .head   (q_head),
    .q_stat (q_stat),
    .q_pop  (q_pop),
    .sums   (sums)
  );

  `BSS_CHECK(a_no_push_full, q_push, !q_stat.full, "run pushed into a full queue")
  `BSS_CHECK(a_no_pop_empty, q_pop, !q_stat.empty, "run popped from an empty queue")
  `BSS_CHECK_NEXT(a_push_fills, q_push && !q_pop, !q_stat.empty, "queue empty after a push")

endmodule
